[rtl/core/cep_pkg.sv]
// ----------------------------------------------------------------------------
// cep_pkg
// Shared constants, effect codes and channel operation types for the colour
// effect post-processor.
// ----------------------------------------------------------------------------
package cep_pkg;

    // Sample format: unsigned Q1.15, 32768 is 1.0
    localparam int unsigned VAL_W = 16;
    localparam int unsigned K_W   = 17;    // unsigned Q1.16 factor
    localparam int unsigned OFF_W = 14;
    localparam int unsigned NCH   = 5;     // red, green, blue, brightness, saturation
    localparam int unsigned NSTG  = 6;

    localparam int unsigned CH_R  = 0;
    localparam int unsigned CH_G  = 1;
    localparam int unsigned CH_B  = 2;
    localparam int unsigned CH_BR = 3;
    localparam int unsigned CH_S  = 4;

    localparam logic [VAL_W-1:0] ONE  = 16'd32768;
    localparam logic [VAL_W-1:0] HALF = 16'd16384;

    // Constant factors, unsigned Q1.16
    localparam logic [K_W-1:0] K_ONE  = 17'd65536;
    localparam logic [K_W-1:0] K0_2   = 17'd13107;
    localparam logic [K_W-1:0] K0_4   = 17'd26214;
    localparam logic [K_W-1:0] K0_5   = 17'd32768;
    localparam logic [K_W-1:0] K0_6   = 17'd39322;
    localparam logic [K_W-1:0] K0_7   = 17'd45875;
    localparam logic [K_W-1:0] K0_75  = 17'd49152;
    localparam logic [K_W-1:0] K0_8   = 17'd52429;
    localparam logic [K_W-1:0] K1_1   = 17'd72090;
    localparam logic [K_W-1:0] K1_2   = 17'd78643;
    localparam logic [K_W-1:0] K1_3   = 17'd85197;
    localparam logic [K_W-1:0] K1_4   = 17'd91750;
    localparam logic [K_W-1:0] K1_5   = 17'd98304;
    localparam logic [K_W-1:0] K1_8   = 17'd117965;

    // BT.601 grey weights, summing to 65536
    localparam logic [VAL_W-1:0] W_R = 16'd19595;
    localparam logic [VAL_W-1:0] W_G = 16'd38470;
    localparam logic [VAL_W-1:0] W_B = 16'd7471;

    // Additive offsets
    localparam logic [OFF_W-1:0] OFF_FILM   = 14'd8192;
    localparam logic [OFF_W-1:0] OFF_VIDEO  = 14'd12288;
    localparam logic [OFF_W-1:0] OFF_BRIGHT = 14'd4915;

    // Reciprocal of three: floor(m / 3) = (m * RECIP3) >> RECIP3_SH for m < 2^19
    localparam logic [18:0] RECIP3    = 19'd349526;
    localparam int unsigned RECIP3_SH = 20;

    localparam logic [31:0] GREY_MID = 32'h4000_0000;   // 0.5 in the weighted sum
    localparam logic [17:0] SUM_MID  = 18'd49152;       // 1.5 as r + g + b

    typedef enum logic [4:0] {
        EFF_PASS                = 5'd0,
        EFF_COLOR_MUTED         = 5'd1,
        EFF_VIDEO_GRAINY        = 5'd2,
        EFF_FILM_16MM           = 5'd3,
        EFF_SHITTY_TV           = 5'd4,
        EFF_BLOOM               = 5'd5,
        EFF_SEPIA_INK           = 5'd6,
        EFF_SILVERTONE          = 5'd7,
        EFF_FILM_BW             = 5'd8,
        EFF_VIDEO_BW            = 5'd9,
        EFF_CONTRAST_BW         = 5'd10,
        EFF_PHOTOCOPY           = 5'd11,
        EFF_BLUE_FILTER         = 5'd12,
        EFF_DESAT_BLUE          = 5'd13,
        EFF_VIDEO_SECURITY      = 5'd14,
        EFF_BRIGHT              = 5'd15,
        EFF_POSTERIZE           = 5'd16,
        EFF_CLEAN_TRAILS        = 5'd17,
        EFF_VIDEO_TRAILS        = 5'd18,
        EFF_FLICKER_TRAILS      = 5'd19,
        EFF_DESAT_POSTERIZE     = 5'd20,
        EFF_FILM_CONTRAST       = 5'd21,
        EFF_FILM_CONTRAST_BLUE  = 5'd22,
        EFF_FILM_CONTRAST_GREEN = 5'd23,
        EFF_FILM_CONTRAST_RED   = 5'd24,
        EFF_HORROR_MOVIE        = 5'd25,
        EFF_PHOTO_NEGATIVE      = 5'd26,
        EFF_MIRROR              = 5'd27,
        EFF_PSYCH_BLUE_RED      = 5'd28,
        EFF_SPACE_WOOSH         = 5'd29
    } t_effect;

    // Per-channel work: round(round(x * k) + off, clamp) then round(. * k2, clamp2)
    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [K_W-1:0]   k;
        logic [OFF_W-1:0] off;
        logic             clamp;
        logic [K_W-1:0]   k2;
        logic             clamp2;
    } t_ch_op;

    typedef t_ch_op [NCH-1:0] t_ops;
    typedef logic [NCH-1:0] [VAL_W-1:0] t_vals;

    // Four-level posterize output for a level code
    function automatic logic [VAL_W-1:0] poster_level(input logic [1:0] lvl);
        logic [VAL_W-1:0] v;
        unique case (lvl)
            2'd0:    v = 16'd0;
            2'd1:    v = 16'd10923;
            2'd2:    v = 16'd21845;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/color_effect_post_processor.sv]
// ----------------------------------------------------------------------------
// color_effect_post_processor
// Applies one of thirty colour effects to a stream of light samples
// (red, green, blue, brightness, saturation, unsigned Q1.15).
//
//   channel   direction  beat contents (lowest bits first)
//   s_axis    in         red_in, green_in, blue_in, bright_in, sat_in
//   m_axis    out        red_out, green_out, blue_out, bright_out, sat_out
//   cfg       in         effect_mode, written when i_cfg_wr_en is high
//
// Six register stages; one beat is taken every cycle when the output is not
// stalled. The grey sum and the operation select each have their own stage;
// each of the two multiply/round passes has a multiply stage and a round stage.
// Each stage holds while its successor is full and stalled, so an empty
// stage still fills: the input keeps flowing into any bubble.
// Reset (synchronous, active low) empties the pipeline and sets the mode
// to pass-through.
// ----------------------------------------------------------------------------
module color_effect_post_processor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,      // effect_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,       // red_in, green_in, blue_in, bright_in, sat_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata        // red_out, green_out, blue_out, bright_out, sat_out
);
    import cep_pkg::*;

    logic [4:0]      r_mode;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    t_vals           in_vals;
    t_vals           out_vals;
    t_ops            ops;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= EFF_PASS;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // Stage enables: a stage loads when empty or when its successor moves on
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= s_axis_tvalid;
            for (int s = 1; s < NSTG; s++) begin
                if (en[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Unpack and pack beats
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            in_vals[c] = s_axis_tdata[c*VAL_W +: VAL_W];
            m_axis_tdata[c*VAL_W +: VAL_W] = out_vals[c];
        end
    end

    cep_analyse u_analyse (
        .i_clk  (i_clk),
        .i_en   (en[1:0]),
        .i_mode (r_mode),
        .i_vals (in_vals),
        .o_ops  (ops)
    );

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        cep_scale u_scale (
            .i_clk   (i_clk),
            .i_en    (en[5:2]),
            .i_op    (ops[c]),
            .o_value (out_vals[c])
        );
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[NSTG-1];

endmodule

[rtl/core/cep_analyse.sv]
// ----------------------------------------------------------------------------
// cep_analyse
// Front two pipeline stages: grey sum and channel sum, then grey value,
// average, posterize and negative, and the per-channel operation selection.
// ----------------------------------------------------------------------------
module cep_analyse (
    input  logic                       i_clk,
    input  logic [1:0]                 i_en,      // stage load enables, stage 1 in bit 0
    input  logic [4:0]                 i_mode,
    input  cep_pkg::t_vals             i_vals,
    output cep_pkg::t_ops              o_ops
);
    import cep_pkg::*;

    // Stage 1 registers
    logic [4:0]   r_mode1;
    t_vals        r_vals1;
    logic [31:0]  r_wsum;
    logic [17:0]  r_sum3;

    // Stage 2 logic
    logic [15:0]  grey;
    logic         thr;
    logic [17:0]  m3;
    logic [36:0]  avg_prod;
    logic [15:0]  avg;
    logic         hi_sum;
    t_vals        post_v;
    t_vals        neg_v;
    t_ops         n_ops;
    t_ops         r_ops;
    logic [17:0]  tri_x;
    logic [2:0]   lvl;

    // Weighted grey sum and plain channel sum
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mode1 <= i_mode;
            r_vals1 <= i_vals;
            r_wsum  <= 32'(i_vals[CH_R]) * 32'(W_R)
                     + 32'(i_vals[CH_G]) * 32'(W_G)
                     + 32'(i_vals[CH_B]) * 32'(W_B);
            r_sum3  <= 18'(i_vals[CH_R]) + 18'(i_vals[CH_G]) + 18'(i_vals[CH_B]);
        end
    end

    // Derived values
    always_comb begin
        grey     = 16'((33'(r_wsum) + 33'd32768) >> 16);
        thr      = r_wsum > GREY_MID;
        m3       = r_sum3 + 18'd1;
        avg_prod = 37'(m3) * 37'(RECIP3);
        avg      = 16'(avg_prod >> RECIP3_SH);
        hi_sum   = r_sum3 > SUM_MID;
        post_v   = r_vals1;
        neg_v    = r_vals1;
        for (int c = 0; c < 3; c++) begin
            tri_x     = 18'(r_vals1[c]) + 18'(r_vals1[c]) + 18'(r_vals1[c]) + 18'(HALF);
            lvl       = tri_x[17:15];
            post_v[c] = poster_level(lvl > 3'd3 ? 2'd3 : lvl[1:0]);
            neg_v[c]  = r_vals1[c] > ONE ? '0 : ONE - r_vals1[c];
        end
    end

    // Pick operand, factor, offset and clamps per channel
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_ops[c] = '{x: r_vals1[c], k: K_ONE, off: '0, clamp: 1'b0,
                         k2: K_ONE, clamp2: 1'b0};
        end
        unique case (t_effect'(r_mode1))
            EFF_COLOR_MUTED: begin
                n_ops[CH_S].k = K0_7;
            end
            EFF_SHITTY_TV: begin
                n_ops[CH_BR].k     = K1_5;
                n_ops[CH_BR].clamp = 1'b1;
                for (int c = 0; c < 3; c++) begin
                    n_ops[c].k     = K1_3;
                    n_ops[c].clamp = 1'b1;
                end
            end
            EFF_BLOOM: begin
                n_ops[CH_BR].k     = K1_2;
                n_ops[CH_BR].clamp = 1'b1;
            end
            EFF_SEPIA_INK: begin
                for (int c = 0; c < 3; c++) n_ops[c].x = grey;
                n_ops[CH_R].k     = K1_2;
                n_ops[CH_R].clamp = 1'b1;
                n_ops[CH_G].clamp = 1'b1;
                n_ops[CH_B].k     = K0_6;
            end
            EFF_SILVERTONE: begin
                for (int c = 0; c < 3; c++) n_ops[c].x = grey;
                n_ops[CH_S].x = '0;
            end
            EFF_FILM_BW: begin
                for (int c = 0; c < 3; c++) begin
                    n_ops[c].x   = grey;
                    n_ops[c].k   = K0_75;
                    n_ops[c].off = OFF_FILM;
                end
                n_ops[CH_S].x = '0;
            end
            EFF_VIDEO_BW, EFF_PHOTOCOPY: begin
                for (int c = 0; c < 3; c++) begin
                    n_ops[c].x   = grey;
                    n_ops[c].k   = K0_5;
                    n_ops[c].off = OFF_VIDEO;
                end
                n_ops[CH_S].x = '0;
            end
            EFF_CONTRAST_BW: begin
                for (int c = 0; c < 3; c++) n_ops[c].x = thr ? ONE : '0;
                n_ops[CH_S].x = '0;
            end
            EFF_BLUE_FILTER: begin
                n_ops[CH_R].k     = K0_2;
                n_ops[CH_G].k     = K0_4;
                n_ops[CH_B].k     = K1_2;
                n_ops[CH_B].clamp = 1'b1;
            end
            EFF_DESAT_BLUE: begin
                n_ops[CH_S].k     = K0_8;
                n_ops[CH_B].k     = K1_1;
                n_ops[CH_B].clamp = 1'b1;
            end
            EFF_VIDEO_SECURITY: begin
                n_ops[CH_R].k     = K0_2;
                n_ops[CH_B].k     = K0_2;
                n_ops[CH_G].k     = K1_3;
                n_ops[CH_G].clamp = 1'b1;
            end
            EFF_BRIGHT: begin
                n_ops[CH_BR].k     = K1_4;
                n_ops[CH_BR].clamp = 1'b1;
                for (int c = 0; c < 3; c++) begin
                    n_ops[c].off   = OFF_BRIGHT;
                    n_ops[c].clamp = 1'b1;
                end
            end
            EFF_POSTERIZE: begin
                for (int c = 0; c < 3; c++) n_ops[c].x = post_v[c];
            end
            EFF_DESAT_POSTERIZE: begin
                for (int c = 0; c < 3; c++) n_ops[c].x = post_v[c];
                n_ops[CH_S].k = K0_6;
            end
            EFF_FLICKER_TRAILS: begin
                n_ops[CH_BR].k = K0_8;
                n_ops[CH_S].k  = K0_7;
            end
            EFF_FILM_CONTRAST, EFF_FILM_CONTRAST_BLUE,
            EFF_FILM_CONTRAST_GREEN, EFF_FILM_CONTRAST_RED: begin
                // split at 0.5, then boost the tinted channel
                for (int c = 0; c < 3; c++) begin
                    n_ops[c].k     = r_vals1[c] < HALF ? K0_7 : K1_3;
                    n_ops[c].clamp = 1'b1;
                end
                if (t_effect'(r_mode1) == EFF_FILM_CONTRAST_BLUE) begin
                    n_ops[CH_B].k2     = K1_1;
                    n_ops[CH_B].clamp2 = 1'b1;
                end
                if (t_effect'(r_mode1) == EFF_FILM_CONTRAST_GREEN) begin
                    n_ops[CH_G].k2     = K1_1;
                    n_ops[CH_G].clamp2 = 1'b1;
                end
                if (t_effect'(r_mode1) == EFF_FILM_CONTRAST_RED) begin
                    n_ops[CH_R].k2     = K1_1;
                    n_ops[CH_R].clamp2 = 1'b1;
                end
            end
            EFF_HORROR_MOVIE: begin
                n_ops[CH_G].k     = K0_2;
                n_ops[CH_B].k     = K0_2;
                n_ops[CH_R].k     = K1_5;
                n_ops[CH_R].clamp = 1'b1;
            end
            EFF_PHOTO_NEGATIVE: begin
                for (int c = 0; c < 3; c++) n_ops[c].x = neg_v[c];
            end
            EFF_MIRROR: begin
                for (int c = 0; c < 3; c++) n_ops[c].x = avg;
                n_ops[CH_R].k     = K1_2;
                n_ops[CH_R].clamp = 1'b1;
                n_ops[CH_G].k     = K1_1;
                n_ops[CH_G].clamp = 1'b1;
                n_ops[CH_B].k     = K0_6;
            end
            EFF_PSYCH_BLUE_RED: begin
                n_ops[CH_R].x = hi_sum ? ONE : '0;
                n_ops[CH_G].x = '0;
                n_ops[CH_B].x = hi_sum ? '0 : ONE;
            end
            EFF_SPACE_WOOSH: begin
                n_ops[CH_BR].x = ONE;
                for (int c = 0; c < 3; c++) begin
                    n_ops[c].k     = K1_8;
                    n_ops[c].clamp = 1'b1;
                end
            end
            default: begin
                // pass-through, trails, grain, 16mm film and unused codes leave the sample alone
            end
        endcase
    end

    // Stage 2 register
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ops <= n_ops;
        end
    end

    assign o_ops = r_ops;

endmodule

[rtl/core/cep_scale.sv]
// ----------------------------------------------------------------------------
// cep_scale
// One channel of the back end: multiply, round and clamp with offset, then a
// second multiply, round and clamp. Four register stages.
// ----------------------------------------------------------------------------
module cep_scale (
    input  logic                       i_clk,
    input  logic [3:0]                 i_en,      // stages 3 to 6, stage 3 in bit 0
    input  cep_pkg::t_ch_op            i_op,
    output logic [cep_pkg::VAL_W-1:0]  o_value
);
    import cep_pkg::*;

    logic [32:0]      r_prod;
    logic [OFF_W-1:0] r_off;
    logic             r_clamp;
    logic [K_W-1:0]   r_k2_3;
    logic             r_clamp2_3;

    logic [16:0]      rnd1;
    logic [17:0]      sum1;
    logic [VAL_W-1:0] n_v;
    logic [VAL_W-1:0] r_v;
    logic [K_W-1:0]   r_k2_4;
    logic             r_clamp2_4;

    logic [32:0]      r_prod2;
    logic             r_clamp2_5;
    logic [16:0]      rnd2;
    logic [VAL_W-1:0] n_out;
    logic [VAL_W-1:0] r_out;

    // Stage 3: first product
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod     <= 33'(i_op.x) * 33'(i_op.k);
            r_off      <= i_op.off;
            r_clamp    <= i_op.clamp;
            r_k2_3     <= i_op.k2;
            r_clamp2_3 <= i_op.clamp2;
        end
    end

    // Stage 4: round half up, add offset, clamp to 1.0 when clamp is set
    always_comb begin
        rnd1 = 17'((34'(r_prod) + 34'd32768) >> 16);
        sum1 = 18'(rnd1) + 18'(r_off);
        n_v  = (r_clamp && sum1 > 18'(ONE)) ? ONE : sum1[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_v        <= n_v;
            r_k2_4     <= r_k2_3;
            r_clamp2_4 <= r_clamp2_3;
        end
    end

    // Stage 5: second product
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_prod2    <= 33'(r_v) * 33'(r_k2_4);
            r_clamp2_5 <= r_clamp2_4;
        end
    end

    // Stage 6: round and clamp into the output register
    always_comb begin
        rnd2  = 17'((34'(r_prod2) + 34'd32768) >> 16);
        n_out = (r_clamp2_5 && rnd2 > 17'(ONE)) ? ONE : rnd2[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_out <= n_out;
        end
    end

    assign o_value = r_out;

endmodule
